// ----- rtl/psc_pkg.sv -----
// Shared types, widths and register codes for the clamped PID step block.
package psc_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned INTEG_W   = 48;
    localparam int unsigned OPND_W    = 33;
    localparam int unsigned PROD_W    = 64;
    localparam int unsigned NUM_W     = 49;
    localparam int unsigned ACC_W     = 82;
    localparam int unsigned VAL_W     = 66;
    localparam int unsigned DIV_CNT_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEGRAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW     = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INT_MUL,
        S_INT_ADD,
        S_P_MUL,
        S_IH_MUL,
        S_IL_MUL,
        S_IL_ACC,
        S_D_WAIT,
        S_D_MUL,
        S_D_ACC,
        S_NEG,
        S_DONE
    } state_t;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [NUM_W-1:0] num;
        logic [DATA_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quot;
    } div_rsp_t;

endpackage

// ----- rtl/pid_step_clamped.sv -----
// Clamped PID step: sequencer, state, configuration and output register.
//
//   port group  direction  handshake               word
//   in          in         in_valid / in_stall     error_sample, step_time
//   out         out        out_valid / out_stall   drive
//   cfg         in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// The 49-step restoring divider sets the longer path from acceptance to a
// loaded result, taken when the derivative is divided; the first word or a
// zero step skips it. The shared 33x33 multiplier is used five times.
// in_stall is high while a word is in work.
// Reset clears the integral, the previous error and the gains, opens the
// limits fully and marks the next word as the first. A stalled result holds
// in the output register; a new word is accepted while it waits.
module pid_step_clamped (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [psc_pkg::DATA_W-1:0]    error_sample,
    input  logic        [psc_pkg::DATA_W-1:0]    step_time,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [psc_pkg::DATA_W-1:0]    drive,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [psc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [psc_pkg::DATA_W-1:0]    cfg_data
);

    psc_pkg::state_t state_reg, state_next;

    logic signed [psc_pkg::DATA_W-1:0]  gain_prop_reg;
    logic signed [psc_pkg::DATA_W-1:0]  gain_integral_reg;
    logic signed [psc_pkg::DATA_W-1:0]  gain_deriv_reg;
    logic signed [psc_pkg::DATA_W-1:0]  limit_high_reg;
    logic signed [psc_pkg::DATA_W-1:0]  limit_low_reg;

    logic signed [psc_pkg::INTEG_W-1:0] integral_reg, integral_next;
    logic signed [psc_pkg::DATA_W-1:0]  last_error_reg, last_error_next;
    logic                               first_reg, first_next;
    logic signed [psc_pkg::DATA_W-1:0]  err_reg, err_next;
    logic        [psc_pkg::DATA_W-1:0]  dt_reg, dt_next;
    logic                               use_div_reg, use_div_next;
    logic signed [psc_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic signed [psc_pkg::VAL_W-1:0]   val_reg, val_next;
    logic signed [psc_pkg::DATA_W-1:0]  drive_reg, drive_next;
    logic                               out_valid_reg, out_valid_next;

    logic signed [psc_pkg::OPND_W-1:0]  op_a, op_b;
    logic signed [psc_pkg::PROD_W-1:0]  prod;
    psc_pkg::div_req_t                  div_req;
    psc_pkg::div_rsp_t                  div_rsp;

    logic signed [psc_pkg::DATA_W:0]    diff;
    logic        [psc_pkg::DATA_W:0]    diff_mag;
    logic signed [psc_pkg::INTEG_W:0]   integ_sum;
    logic signed [psc_pkg::INTEG_W-1:0] integ_inc;
    logic signed [psc_pkg::DATA_W-1:0]  deriv;
    logic signed [psc_pkg::ACC_W-1:0]   acc_neg;
    logic signed [psc_pkg::VAL_W-1:0]   lim_lo_w, lim_hi_w;
    logic signed [psc_pkg::DATA_W-1:0]  clamped;

    psc_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    psc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall  = (state_reg != psc_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign cfg_ready = 1'b1;

    assign diff      = {err_reg[psc_pkg::DATA_W-1], err_reg}
                     - {last_error_reg[psc_pkg::DATA_W-1], last_error_reg};
    assign diff_mag  = diff[psc_pkg::DATA_W] ? -diff : diff;
    assign integ_inc = prod[psc_pkg::PROD_W-1:16];
    assign integ_sum = {integral_reg[psc_pkg::INTEG_W-1], integral_reg}
                     + {integ_inc[psc_pkg::INTEG_W-1], integ_inc};
    assign deriv     = use_div_reg ? div_rsp.quot : '0;
    assign acc_neg   = -acc_reg;
    assign lim_lo_w  = psc_pkg::VAL_W'(limit_low_reg);
    assign lim_hi_w  = psc_pkg::VAL_W'(limit_high_reg);

    // low limit wins when the limits cross
    always_comb
    begin
        if (val_reg < lim_lo_w)
            clamped = limit_low_reg;
        else if (val_reg > lim_hi_w)
            clamped = limit_high_reg;
        else
            clamped = val_reg[psc_pkg::DATA_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        integral_next   = integral_reg;
        last_error_next = last_error_reg;
        first_next      = first_reg;
        err_next        = err_reg;
        dt_next         = dt_reg;
        use_div_next    = use_div_reg;
        acc_next        = acc_reg;
        val_next        = val_reg;
        drive_next      = drive_reg;
        out_valid_next  = out_valid_reg && out_stall;
        op_a            = '0;
        op_b            = '0;
        div_req.start   = 1'b0;
        div_req.neg     = diff[psc_pkg::DATA_W];
        div_req.num     = {diff_mag, 16'b0};
        div_req.den     = dt_reg;

        case (state_reg)
            psc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    err_next   = error_sample;
                    dt_next    = step_time;
                    state_next = psc_pkg::S_INT_MUL;
                end
            end
            psc_pkg::S_INT_MUL:
            begin
                op_a          = psc_pkg::OPND_W'(err_reg);
                op_b          = {1'b0, dt_reg};
                use_div_next  = !first_reg && (dt_reg != '0);
                div_req.start = !first_reg && (dt_reg != '0);
                state_next    = psc_pkg::S_INT_ADD;
            end
            psc_pkg::S_INT_ADD:
            begin
                if (integ_sum[psc_pkg::INTEG_W] != integ_sum[psc_pkg::INTEG_W-1])
                    integral_next = integ_sum[psc_pkg::INTEG_W]
                        ? {1'b1, {(psc_pkg::INTEG_W-1){1'b0}}}
                        : {1'b0, {(psc_pkg::INTEG_W-1){1'b1}}};
                else
                    integral_next = integ_sum[psc_pkg::INTEG_W-1:0];
                last_error_next = err_reg;
                first_next      = 1'b0;
                state_next      = psc_pkg::S_P_MUL;
            end
            psc_pkg::S_P_MUL:
            begin
                op_a       = psc_pkg::OPND_W'(gain_prop_reg);
                op_b       = psc_pkg::OPND_W'(err_reg);
                state_next = psc_pkg::S_IH_MUL;
            end
            psc_pkg::S_IH_MUL:
            begin
                op_a       = psc_pkg::OPND_W'(gain_integral_reg);
                op_b       = {integral_reg[psc_pkg::INTEG_W-1],
                              integral_reg[psc_pkg::INTEG_W-1:16]};
                acc_next   = psc_pkg::ACC_W'(prod);
                state_next = psc_pkg::S_IL_MUL;
            end
            psc_pkg::S_IL_MUL:
            begin
                op_a       = psc_pkg::OPND_W'(gain_integral_reg);
                op_b       = {17'b0, integral_reg[15:0]};
                acc_next   = acc_reg + {prod[psc_pkg::PROD_W-1], prod[psc_pkg::PROD_W-1],
                                        prod, 16'b0};
                state_next = psc_pkg::S_IL_ACC;
            end
            psc_pkg::S_IL_ACC:
            begin
                acc_next   = acc_reg + psc_pkg::ACC_W'(prod);
                state_next = psc_pkg::S_D_WAIT;
            end
            psc_pkg::S_D_WAIT:
            begin
                if (!use_div_reg || div_rsp.done)
                    state_next = psc_pkg::S_D_MUL;
            end
            psc_pkg::S_D_MUL:
            begin
                op_a       = psc_pkg::OPND_W'(gain_deriv_reg);
                op_b       = psc_pkg::OPND_W'(deriv);
                state_next = psc_pkg::S_D_ACC;
            end
            psc_pkg::S_D_ACC:
            begin
                acc_next   = acc_reg + psc_pkg::ACC_W'(prod);
                state_next = psc_pkg::S_NEG;
            end
            psc_pkg::S_NEG:
            begin
                // floor of the negated sum, back to Q16.16
                val_next   = acc_neg[psc_pkg::ACC_W-1:16];
                state_next = psc_pkg::S_DONE;
            end
            psc_pkg::S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    drive_next     = clamped;
                    out_valid_next = 1'b1;
                    state_next     = psc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = psc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg   <= '0;
            last_error_reg <= '0;
            first_reg      <= 1'b1;
            use_div_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            integral_reg   <= integral_next;
            last_error_reg <= last_error_next;
            first_reg      <= first_next;
            use_div_reg    <= use_div_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg     <= '0;
            gain_integral_reg <= '0;
            gain_deriv_reg    <= '0;
            limit_high_reg    <= {1'b0, {(psc_pkg::DATA_W-1){1'b1}}};
            limit_low_reg     <= {1'b1, {(psc_pkg::DATA_W-1){1'b0}}};
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                psc_pkg::REG_GAIN_PROP:     gain_prop_reg     <= cfg_data;
                psc_pkg::REG_GAIN_INTEGRAL: gain_integral_reg <= cfg_data;
                psc_pkg::REG_GAIN_DERIV:    gain_deriv_reg    <= cfg_data;
                psc_pkg::REG_LIMIT_HIGH:    limit_high_reg    <= cfg_data;
                psc_pkg::REG_LIMIT_LOW:     limit_low_reg     <= cfg_data;
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        dt_reg    <= dt_next;
        acc_reg   <= acc_next;
        val_reg   <= val_next;
        drive_reg <= drive_next;
    end

endmodule

// ----- rtl/psc_mul.sv -----
// Shared signed multiplier with registered product.
module psc_mul (
    input  logic                                clk,
    input  logic signed [psc_pkg::OPND_W-1:0]  op_a,
    input  logic signed [psc_pkg::OPND_W-1:0]  op_b,
    output logic signed [psc_pkg::PROD_W-1:0]  prod
);

    logic signed [2*psc_pkg::OPND_W-1:0] full;
    logic signed [psc_pkg::PROD_W-1:0]   prod_reg;

    // operand ranges keep every product inside 64 bits
    assign full = op_a * op_b;
    assign prod = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= full[psc_pkg::PROD_W-1:0];
    end

endmodule

// ----- rtl/psc_div.sv -----
// Restoring divider for the derivative term, one quotient bit per cycle, saturated.
module psc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  psc_pkg::div_req_t req,
    output psc_pkg::div_rsp_t rsp
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic                           neg_reg, neg_next;
    logic [psc_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [psc_pkg::NUM_W-1:0]      num_reg, num_next;
    logic [psc_pkg::DATA_W-1:0]     rem_reg, rem_next;
    logic [psc_pkg::DATA_W-1:0]     den_reg, den_next;
    logic [psc_pkg::DATA_W:0]       rem_shift;
    logic [psc_pkg::DATA_W:0]       rem_diff;
    logic                           qbit;
    logic [psc_pkg::DATA_W-1:0]     quot_sat;

    assign rem_shift = {rem_reg, num_reg[psc_pkg::NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign qbit      = !rem_diff[psc_pkg::DATA_W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            neg_next  = req.neg;
            cnt_next  = psc_pkg::DIV_CNT_W'(psc_pkg::NUM_W - 1);
            num_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, keep the difference when it fits
            rem_next = qbit ? rem_diff[psc_pkg::DATA_W-1:0]
                            : rem_shift[psc_pkg::DATA_W-1:0];
            num_next = {num_reg[psc_pkg::NUM_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (!neg_reg)
        begin
            if (num_reg[psc_pkg::NUM_W-1:psc_pkg::DATA_W-1] != '0)
                quot_sat = {1'b0, {(psc_pkg::DATA_W-1){1'b1}}};
            else
                quot_sat = num_reg[psc_pkg::DATA_W-1:0];
        end
        else
        begin
            if (num_reg[psc_pkg::NUM_W-1:psc_pkg::DATA_W] != '0 ||
                (num_reg[psc_pkg::DATA_W-1] && num_reg[psc_pkg::DATA_W-2:0] != '0))
                quot_sat = {1'b1, {(psc_pkg::DATA_W-1){1'b0}}};
            else
                quot_sat = -num_reg[psc_pkg::DATA_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the clamped PID step block.
`timescale 1ns / 100ps

module tb;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned PHASES      = 13;
    localparam int unsigned WORDS       = 80;
    localparam int unsigned HOLD_CYCLES = 400;

    localparam logic signed [127:0] ACC_MAX   = (128'sd1 <<< 47) - 128'sd1;
    localparam logic signed [127:0] ACC_MIN   = -(128'sd1 <<< 47);
    localparam logic signed [127:0] SLOPE_MAX = 128'sd2147483647;
    localparam logic signed [127:0] SLOPE_MIN = -128'sd2147483648;

    typedef struct {
        logic signed [31:0] err;
        logic        [31:0] dt;
    } sample_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                                 in_valid     = 1'b0;
    logic                                 in_stall;
    logic signed [psc_pkg::DATA_W-1:0]    error_sample = '0;
    logic        [psc_pkg::DATA_W-1:0]    step_time    = '0;
    logic                                 out_valid;
    logic                                 out_stall    = 1'b0;
    logic signed [psc_pkg::DATA_W-1:0]    drive;
    logic                                 cfg_valid    = 1'b0;
    logic                                 cfg_ready;
    logic        [psc_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
    logic        [psc_pkg::DATA_W-1:0]    cfg_data     = '0;

    // register shadow
    logic signed [31:0] gain_p_sh   = '0;
    logic signed [31:0] gain_i_sh   = '0;
    logic signed [31:0] gain_d_sh   = '0;
    logic signed [31:0] lim_high_sh = 32'sh7FFF_FFFF;
    logic signed [31:0] lim_low_sh  = 32'sh8000_0000;

    // controller state shadow
    logic signed [47:0] integ_acc = '0;
    logic signed [31:0] prev_err  = '0;
    logic               fresh     = 1'b1;

    sample_t            sample_q[$];
    logic signed [31:0] drive_q[$];
    sample_t            next_word;
    logic signed [31:0] want;

    logic        in_burst  = 1'b0;
    logic        out_burst = 1'b0;
    logic        hold_off  = 1'b0;
    int unsigned in_gap    = 0;
    int unsigned out_gap   = 0;
    int unsigned nxt_gap;
    int unsigned fails       = 0;
    int unsigned cycle_count = 0;

    pid_step_clamped dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .error_sample (error_sample),
        .step_time    (step_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .drive        (drive),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // One control step: update integral and previous error, return the clamped drive.
    function automatic logic signed [31:0] predict_drive(input logic signed [31:0] err,
                                                         input logic        [31:0] dt);
        logic signed [127:0] e, d, pe, acc, slope, sum, v, kp, ki, kd, hi, lo;
        e     = err;
        d     = {96'd0, dt};
        pe    = prev_err;
        kp    = gain_p_sh;
        ki    = gain_i_sh;
        kd    = gain_d_sh;
        hi    = lim_high_sh;
        lo    = lim_low_sh;
        acc   = integ_acc;
        acc   = acc + ((e * d) >>> 16);
        if (acc > ACC_MAX)
            acc = ACC_MAX;
        else if (acc < ACC_MIN)
            acc = ACC_MIN;
        integ_acc = acc[47:0];
        slope = '0;
        if (!fresh && dt != 0)
        begin
            slope = ((e - pe) <<< 16) / d;
            if (slope > SLOPE_MAX)
                slope = SLOPE_MAX;
            else if (slope < SLOPE_MIN)
                slope = SLOPE_MIN;
        end
        sum = kp * e + ki * acc + kd * slope;
        // negate before the shift so the drop of fraction bits rounds down
        v = (-sum) >>> 16;
        if (v < lo)
            v = lo;
        else if (v > hi)
            v = hi;
        prev_err = err;
        fresh    = 1'b0;
        return v[31:0];
    endfunction

    function automatic logic [31:0] rand_err();
        logic [31:0] r;
        r = $urandom_range(0, 32'h0003_FFFF);
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return $urandom;
            default: return $urandom_range(0, 1) ? -r : r;
        endcase
    endfunction

    function automatic logic [31:0] rand_dt();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom;
            default: return $urandom_range(1, 32'h0002_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_gain();
        logic [31:0] r;
        r = $urandom_range(0, 32'h0004_0000);
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return $urandom;
            default: return $urandom_range(0, 1) ? -r : r;
        endcase
    endfunction

    task automatic add_sample(input logic [31:0] e, input logic [31:0] t);
        sample_q.push_back('{e, t});
    endtask

    task automatic write_reg(input logic [psc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0]                   val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            psc_pkg::REG_GAIN_PROP:     gain_p_sh   = val;
            psc_pkg::REG_GAIN_INTEGRAL: gain_i_sh   = val;
            psc_pkg::REG_GAIN_DERIV:    gain_d_sh   = val;
            psc_pkg::REG_LIMIT_HIGH:    lim_high_sh = val;
            psc_pkg::REG_LIMIT_LOW:     lim_low_sh  = val;
            default:                    ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] gp, input logic [31:0] gi,
                             input logic [31:0] gd, input logic [31:0] lh,
                             input logic [31:0] ll);
        write_reg(psc_pkg::REG_GAIN_PROP, gp);
        write_reg(psc_pkg::REG_GAIN_INTEGRAL, gi);
        write_reg(psc_pkg::REG_GAIN_DERIV, gd);
        write_reg(psc_pkg::REG_LIMIT_HIGH, lh);
        write_reg(psc_pkg::REG_LIMIT_LOW, ll);
        // an index past the last register must leave everything alone
        write_reg(psc_pkg::REG_LIMIT_LOW + 3'($urandom_range(1, 3)), $urandom);
    endtask

    // Sample on the falling edge so queue updates of this cycle are settled.
    task automatic wait_idle();
        do @(negedge clk); while (sample_q.size() != 0 || in_valid || drive_q.size() != 0);
        @(posedge clk);
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
                drive_q.push_back(predict_drive(error_sample, step_time));
            if (in_gap != 0)
            begin
                in_gap   <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (sample_q.size() != 0)
            begin
                next_word    = sample_q.pop_front();
                error_sample <= next_word.err;
                step_time    <= next_word.dt;
                in_valid     <= 1'b1;
                in_gap       <= in_burst ? 0 : $urandom_range(0, 13);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            nxt_gap = out_gap;
            if (out_valid && !out_stall)
            begin
                if (drive_q.size() == 0)
                begin
                    $error("drive: unexpected word %0d", drive);
                    fails++;
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (drive !== want)
                    begin
                        $error("drive: expected %0d, got %0d", want, drive);
                        fails++;
                    end
                end
                nxt_gap = out_burst ? 0 : $urandom_range(0, 13);
            end
            out_stall <= hold_off || (nxt_gap != 0);
            out_gap   <= (nxt_gap != 0) ? nxt_gap - 1 : 0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : main
        int unsigned ph;
        int unsigned n;
        logic [31:0] lh, ll, r;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_sample(32'h0003_0000, 32'h0001_0000);   // first word: no derivative
        add_sample(32'h7FFF_FFFF, 32'h0000_0000);   // zero step
        add_sample(32'h8000_0000, 32'h0000_0001);   // derivative saturates low
        add_sample(32'h7FFF_FFFF, 32'h0000_0001);   // derivative saturates high
        add_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF);   // integral to its top
        add_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_sample(32'h8000_0000, 32'hFFFF_FFFF);   // and down to its bottom
        add_sample(32'h8000_0000, 32'hFFFF_FFFF);
        add_sample(32'h8000_0000, 32'hFFFF_FFFF);
        add_sample(32'hFFFF_FFFF, 32'h0000_0001);   // tiny negative increment rounds down
        add_sample(32'h0000_0001, 32'h0000_0001);
        add_sample(32'h0000_0000, 32'hFFFF_FFFF);
        wait_idle();

        // crossed limits: low test wins
        configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0001_0000);
        add_sample(32'h1234_0000, 32'h0001_0000);
        add_sample(32'hEDCC_0000, 32'h0001_0000);
        add_sample(32'h0000_0000, 32'h0000_0000);
        add_sample(32'h7FFF_FFFF, 32'h0000_8000);
        wait_idle();

        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0010_0000, 32'hFFF0_0000);
        add_sample(32'h0000_8000, 32'h0000_4000);
        add_sample(32'hFFFF_8000, 32'h0000_4000);
        add_sample(32'h0001_0000, 32'h0000_0000);
        add_sample(32'h8000_0000, 32'h0000_0001);
        wait_idle();

        for (ph = 0; ph < PHASES; ph++)
        begin
            in_burst  <= (ph % 4 == 1) || (ph == 2);
            out_burst <= (ph % 4 == 1) || (ph % 4 == 3);
            r = $urandom_range(0, 32'h00FF_FFFF);
            case ($urandom_range(0, 3))
                0:
                begin
                    lh = 32'h7FFF_FFFF;
                    ll = 32'h8000_0000;
                end
                1:
                begin
                    lh = $urandom;
                    ll = $urandom;
                end
                2:
                begin
                    lh = r;
                    ll = -r;
                end
                default:
                begin
                    lh = 32'h8000_0000;
                    ll = 32'h7FFF_FFFF;
                end
            endcase
            configure(rand_gain(), rand_gain(), rand_gain(), lh, ll);
            for (n = 0; n < WORDS; n++)
                add_sample(rand_err(), rand_dt());
            if (ph == 2)
            begin
                // hold the output long enough for the block to back up its input
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
            wait_idle();
        end

        repeat (80) @(posedge clk);
        if (fails == 0 && drive_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
